// ===== sv/ptwq_pkg.sv =====
// ----------------------------------------------------------------------------
// ptwq_pkg
// Types and codes shared by the per-title waiting queue block.
// ----------------------------------------------------------------------------
`default_nettype none

package ptwq_pkg;

  // operation codes
  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_POP    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_DUP     = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  title_index;
    logic [15:0] member_id;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] member_out;
    logic [2:0]  position;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/per_title_waiting_queues_core.sv =====
// Operations that scan the list pass S_SCAN and S_FINISH before the result register;
//   rejected operations go from S_IDLE straight to S_FINISH.
// Throughput: one operation at a time; no new operation is taken until the slot-by-slot
//   scan over the single read port of the queue memory and the loading of the result are done.
// Reset: control clears at once; a clearing pass then zeroes every entry of the memory,
//   one entry per cycle, before the first operation is taken.
// ----------------------------------------------------------------------------
// per_title_waiting_queues_core
// One gap-free waiting list of member IDs per title, held in a single memory.
// Append, cancel and pop are each run as a read scan of the row; cancel and pop shift later entries forward.
// ----------------------------------------------------------------------------
`default_nettype none

module per_title_waiting_queues_core #(
  parameter int NUM_TITLES  = 256,
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire ptwq_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output ptwq_pkg::out_t      out_o
);

  localparam int TW        = (NUM_TITLES > 1) ? $clog2(NUM_TITLES) : 1;
  localparam int SW        = $clog2(QUEUE_DEPTH);
  localparam int AW        = TW + SW;
  localparam int MEM_DEPTH = 2 ** AW;
  localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e          state_q, state_d;
  ptwq_pkg::in_t   op_q, op_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic [SW-1:0]   rd_slot_q, rd_slot_d;
  logic            rd_live_q, rd_live_d;
  logic            dv_q, dv_d;
  logic [SW-1:0]   dv_slot_q, dv_slot_d;
  logic            rej_q, rej_d;
  logic [2:0]      rej_st_q, rej_st_d;
  logic            dup_q, dup_d;
  logic            free_q, free_d;
  logic [SW-1:0]   free_pos_q, free_pos_d;
  logic            found_q, found_d;
  logic [SW-1:0]   hit_pos_q, hit_pos_d;
  logic [15:0]     member_q, member_d;
  logic            out_valid_q, out_valid_d;
  ptwq_pkg::out_t  out_q, out_d;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     rdata_q;
  logic [15:0]     store_mem [MEM_DEPTH];

  logic [TW-1:0]   title_a;
  logic            title_ok;
  logic            hit;
  logic            out_free;

  assign title_a  = TW'(op_q.title_index);
  assign title_ok = {24'd0, in_i.title_index} < NUM_TITLES;
  assign out_free = !out_valid_q || out_ready_i;

  // pop matches a live front entry; cancel matches the member ID
  assign hit = (op_q.kind == ptwq_pkg::KIND_POP) ? (dv_slot_q == '0 && rdata_q != '0)
                                                 : (rdata_q == op_q.member_id);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    clr_d       = clr_q;
    rd_slot_d   = rd_slot_q;
    rd_live_d   = rd_live_q;
    dv_d        = 1'b0;
    dv_slot_d   = dv_slot_q;
    rej_d       = rej_q;
    rej_st_d    = rej_st_q;
    dup_d       = dup_q;
    free_d      = free_q;
    free_pos_d  = free_pos_q;
    found_d     = found_q;
    hit_pos_d   = hit_pos_q;
    member_d    = member_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_waddr   = {title_a, dv_slot_q};
    mem_wdata   = '0;
    mem_raddr   = {title_a, rd_slot_q};
    in_ready_o  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d       = in_i;
          rd_slot_d  = '0;
          rd_live_d  = 1'b1;
          dup_d      = 1'b0;
          free_d     = 1'b0;
          free_pos_d = '0;
          found_d    = 1'b0;
          hit_pos_d  = '0;
          member_d   = '0;
          rej_d      = 1'b1;
          rej_st_d   = ptwq_pkg::ST_INVALID;
          case (in_i.kind)
            ptwq_pkg::KIND_APPEND: begin
              if (in_i.member_id == '0) begin
                rej_st_d = ptwq_pkg::ST_INVALID;
              end else if (!title_ok) begin
                rej_st_d = ptwq_pkg::ST_FULL;
              end else begin
                rej_d = 1'b0;
              end
            end
            ptwq_pkg::KIND_CANCEL: begin
              if (in_i.member_id == '0) begin
                rej_st_d = ptwq_pkg::ST_INVALID;
              end else if (!title_ok) begin
                rej_st_d = ptwq_pkg::ST_MISSING;
              end else begin
                rej_d = 1'b0;
              end
            end
            ptwq_pkg::KIND_POP: begin
              if (!title_ok) begin
                rej_st_d = ptwq_pkg::ST_MISSING;
              end else begin
                rej_d = 1'b0;
              end
            end
            default: begin
              rej_st_d = ptwq_pkg::ST_INVALID;
            end
          endcase
          // rejected operations skip the scan entirely
          rd_live_d = !rej_d;
          state_d   = rej_d ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        // data checked here comes from the read issued in the previous cycle
        if (rd_live_q) begin
          dv_d      = 1'b1;
          dv_slot_d = rd_slot_q;
          rd_slot_d = rd_slot_q + SW'(1);
          if (rd_slot_q == LAST_SLOT) begin
            rd_live_d = 1'b0;
          end
        end
        if (dv_q) begin
          if (op_q.kind == ptwq_pkg::KIND_APPEND) begin
            if (rdata_q == op_q.member_id) begin
              dup_d = 1'b1;
            end
            if (rdata_q == '0 && !free_q) begin
              free_d     = 1'b1;
              free_pos_d = dv_slot_q;
            end
          end else if (found_q) begin
            // move entry one slot forward
            mem_we    = 1'b1;
            mem_waddr = {title_a, dv_slot_q - SW'(1)};
            mem_wdata = rdata_q;
          end else if (hit) begin
            found_d   = 1'b1;
            hit_pos_d = dv_slot_q;
            member_d  = (op_q.kind == ptwq_pkg::KIND_POP) ? rdata_q : '0;
          end
          if (dv_slot_q == LAST_SLOT) begin
            state_d = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          state_d     = S_IDLE;
          if (rej_q) begin
            out_d.status = rej_st_q;
          end else if (op_q.kind == ptwq_pkg::KIND_APPEND) begin
            if (dup_q) begin
              out_d.status = ptwq_pkg::ST_DUP;
            end else if (!free_q) begin
              out_d.status = ptwq_pkg::ST_FULL;
            end else begin
              out_d.status   = ptwq_pkg::ST_DONE;
              out_d.position = 3'(free_pos_q);
              mem_we         = 1'b1;
              mem_waddr      = {title_a, free_pos_q};
              mem_wdata      = op_q.member_id;
            end
          end else if (found_q) begin
            out_d.status     = ptwq_pkg::ST_DONE;
            out_d.position   = 3'(hit_pos_q);
            out_d.member_out = member_q;
            mem_we           = 1'b1;
            mem_waddr        = {title_a, LAST_SLOT};
            mem_wdata        = '0;
          end else begin
            out_d.status = ptwq_pkg::ST_MISSING;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rd_live_q   <= 1'b0;
      dv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      rej_q       <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      dup_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rd_live_q   <= rd_live_d;
      dv_q        <= dv_d;
      out_valid_q <= out_valid_d;
      rej_q       <= rej_d;
      found_q     <= found_d;
      free_q      <= free_d;
      dup_q       <= dup_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    rd_slot_q  <= rd_slot_d;
    dv_slot_q  <= dv_slot_d;
    rej_st_q   <= rej_st_d;
    free_pos_q <= free_pos_d;
    hit_pos_q  <= hit_pos_d;
    member_q   <= member_d;
    out_q      <= out_d;
  end

  // queue memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= store_mem[mem_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

`ifndef SYNTHESIS
  // failed operations leave the payload fields clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.status != ptwq_pkg::ST_DONE |->
      out_o.member_out == '0 && out_o.position == '0)
    else $error("payload not clear on failed operation");

  // shift writes stay inside the row under work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q == S_SCAN |-> mem_waddr[AW-1:SW] == title_a)
    else $error("shift write left the current row");

  // no transfer taken before the clearing pass is over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !in_ready_o && !dv_q)
    else $error("input taken during clearing pass");

  // a result is loaded only once the scan has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH) && !rd_live_q)
    else $error("result produced outside finish");
`endif

endmodule

`default_nettype wire
